>>> rtl/dpdp_pkg.sv
// dpdp_pkg: sizes, widths and the score ceiling shared by the domino profile block
// and its score ram; depends on nothing
`timescale 1ns / 1ps
`default_nettype none
package dpdp_pkg;
  localparam int MAX_ROWS   = 8;
  localparam int CELL_BITS  = 16;
  localparam int SCORE_BITS = 48;
  localparam int OUT_BITS   = 47;
  localparam int HGT_BITS   = 4;
  localparam int MASK_BITS  = MAX_ROWS;
  localparam int NMASKS     = 1 << MAX_ROWS;
  localparam int ROW_BITS   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  // running sums keep one spare bit so saturation happens once, at the last row
  localparam int ACC_BITS   = SCORE_BITS + 1;
  localparam int ADD_BITS   = CELL_BITS + 1;
  localparam logic [ACC_BITS-1:0] SCORE_CAP = (ACC_BITS'(1) << (SCORE_BITS - 1)) - ACC_BITS'(1);
endpackage
`default_nettype wire

>>> rtl/dpdp_ram.sv
// dpdp_ram: generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module dpdp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> rtl/domino_profile_dp.sv
// domino_profile_dp: max-weight domino placement, broken-profile dp one column per request
// depends on dpdp_pkg and dpdp_ram (ping-pong score banks)
//
//  channel  | direction | handshake            | payload
//  in       | to block  | in_valid / in_stall  | cell_0..cell_7, last_column
//  out      | from block| out_valid / out_stall| best_total, answer_final
//  cfg      | to block  | cfg_valid / cfg_ready| cfg_data (rows_in_use)
//
// each processed column walks rows_in_use rows, clamped to 1..8; each row sweeps all 256 profile
// masks with three source reads per mask through one ram read port, between a row setup step
// and a drain step. a last column that follows another brings two passes: the held column with it,
// then itself alone; the first column of a grid seeds mask 0 and, unless also the last, only stores itself.
// in_stall is high from acceptance until the result is loaded into the output register;
// a stalled output holds the block before its next request. rst is synchronous, no ram clear.
`timescale 1ns / 1ps
`default_nettype none
module domino_profile_dp (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic signed [dpdp_pkg::CELL_BITS-1:0] cell_0,
  input  wire logic signed [dpdp_pkg::CELL_BITS-1:0] cell_1,
  input  wire logic signed [dpdp_pkg::CELL_BITS-1:0] cell_2,
  input  wire logic signed [dpdp_pkg::CELL_BITS-1:0] cell_3,
  input  wire logic signed [dpdp_pkg::CELL_BITS-1:0] cell_4,
  input  wire logic signed [dpdp_pkg::CELL_BITS-1:0] cell_5,
  input  wire logic signed [dpdp_pkg::CELL_BITS-1:0] cell_6,
  input  wire logic signed [dpdp_pkg::CELL_BITS-1:0] cell_7,
  input  wire logic                                last_column,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [dpdp_pkg::OUT_BITS-1:0]            best_total,
  output logic                                     answer_final,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [dpdp_pkg::HGT_BITS-1:0]       cfg_data
);
  localparam int MB = dpdp_pkg::MASK_BITS;
  localparam int RB = dpdp_pkg::ROW_BITS;
  localparam int HB = dpdp_pkg::HGT_BITS;
  localparam int CB = dpdp_pkg::CELL_BITS;
  localparam int AB = dpdp_pkg::ACC_BITS;
  localparam int DB = dpdp_pkg::ADD_BITS;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_INIT   = 3'd1;
  localparam logic [2:0] S_ROWSET = 3'd2;
  localparam logic [2:0] S_SWEEP  = 3'd3;
  localparam logic [2:0] S_DRAIN  = 3'd4;
  localparam logic [2:0] S_FIN    = 3'd5;

  localparam logic [1:0] SLOT_A = 2'd0;
  localparam logic [1:0] SLOT_B = 2'd1;
  localparam logic [1:0] SLOT_C = 2'd2;

  logic [2:0]    state;
  logic [HB-1:0] rows_in_use;
  logic [HB-1:0] hgt;
  logic          last_q;
  logic          phase;
  logic          have_held;
  logic          bank;
  logic [RB-1:0] row;
  logic [MB-1:0] q;
  logic [1:0]    slot;
  logic [AB-1:0] best;
  // read bank holds only the seeded mask 0 (start of a grid)
  logic          fresh;

  logic signed [CB-1:0] newcol [dpdp_pkg::MAX_ROWS];
  logic signed [CB-1:0] held   [dpdp_pkg::MAX_ROWS];
  logic signed [CB-1:0] cur    [dpdp_pkg::MAX_ROWS];
  logic signed [CB-1:0] incol  [dpdp_pkg::MAX_ROWS];

  // per-row pair sums
  logic          sv_pos, sh_pos;
  logic [DB-1:0] sv, sh;

  // issue stage
  logic [MB-1:0] src;
  logic          cond, src_ok;
  logic [DB-1:0] add;
  logic [MB-1:0] rbit, r1bit;
  logic [HB-1:0] r1;
  logic          vert_ok, last_row;

  // data stage
  logic          p_live, p_valid, p_cond;
  logic [DB-1:0] p_add;
  logic [1:0]    p_slot;
  logic [MB-1:0] p_q, p_src;
  logic          acc_v;
  logic [AB-1:0] acc_s;
  logic [AB-1:0] rscore, cand, m_s, sat_s;
  logic          m_v;

  // ram ports: reach flag above the score
  logic          we;
  logic [MB:0]   waddr, raddr;
  logic [AB:0]   wdata, rdata;

  logic signed [CB:0] sum_v, sum_h;
  logic signed [CB-1:0] cell_b;

  assign incol[0] = cell_0;
  assign incol[1] = cell_1;
  assign incol[2] = cell_2;
  assign incol[3] = cell_3;
  assign incol[4] = cell_4;
  assign incol[5] = cell_5;
  assign incol[6] = cell_6;
  assign incol[7] = cell_7;

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  // current column: held one, or the new one when it processes itself
  always_comb begin
    for (int i = 0; i < dpdp_pkg::MAX_ROWS; i++) begin
      cur[i] = phase ? newcol[i] : held[i];
    end
  end

  // row geometry
  assign r1       = HB'(row) + HB'(1);
  assign rbit     = MB'(1) << row;
  assign r1bit    = (r1 < HB'(dpdp_pkg::MAX_ROWS)) ? (MB'(1) << r1) : '0;
  assign vert_ok  = (r1 < hgt);
  assign last_row = (r1 == hgt);
  assign cell_b   = (r1 < HB'(dpdp_pkg::MAX_ROWS)) ? cur[r1[RB-1:0]] : '0;
  assign sum_v    = (CB+1)'(cur[row]) + (CB+1)'(cell_b);
  assign sum_h    = (CB+1)'(cur[row]) + (phase ? '0 : (CB+1)'(newcol[row]));

  // source selection for one destination slot
  always_comb begin
    src  = q;
    cond = 1'b0;
    add  = '0;
    unique case (slot)
      SLOT_A: begin
        if ((q & rbit) != '0) begin
          src  = q & ~rbit;
          cond = !phase && sh_pos;
          add  = sh;
        end else begin
          src  = q | rbit;
          cond = 1'b1;
        end
      end
      SLOT_B: begin
        src  = q;
        cond = ((q & rbit) == '0);
      end
      SLOT_C: begin
        src  = q & ~r1bit;
        cond = ((q & rbit) == '0) && ((q & r1bit) != '0) && vert_ok && sv_pos;
        add  = sv;
      end
      default: begin
        src  = q;
        cond = 1'b0;
      end
    endcase
  end

  assign src_ok = cond && ((src >> hgt) == '0);

  // source is live when its flag is set, or it is mask 0 of a fresh grid
  assign rscore  = rdata[AB-1:0];
  assign p_valid = p_cond && (fresh ? (p_src == '0) : rdata[AB]);

  // shared adder and running max
  assign cand = rscore + AB'(p_add);
  always_comb begin
    if (p_slot == SLOT_A) begin
      m_v = p_valid;
      m_s = cand;
    end else if (p_valid && (!acc_v || cand > acc_s)) begin
      m_v = 1'b1;
      m_s = cand;
    end else begin
      m_v = acc_v;
      m_s = acc_s;
    end
  end
  assign sat_s = (m_s > dpdp_pkg::SCORE_CAP) ? dpdp_pkg::SCORE_CAP : m_s;

  // ram write: seed mask 0, or the finished destination
  always_comb begin
    we    = 1'b0;
    waddr = {~bank, p_q};
    wdata = {m_v, (last_row ? sat_s : m_s)};
    if (state == S_INIT) begin
      we    = 1'b1;
      waddr = {bank, MB'(0)};
      wdata = {1'b1, AB'(0)};
    end else if (p_live && p_slot == SLOT_C) begin
      we = 1'b1;
    end
  end
  assign raddr = {bank, src};

  dpdp_ram #(
    .WIDTH (AB + 1),
    .DEPTH (2 * dpdp_pkg::NMASKS)
  ) u_scores (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // data stage registers
  always_ff @(posedge clk) begin
    p_cond  <= src_ok;
    p_src   <= src;
    p_add   <= add;
    p_slot  <= slot;
    p_q     <= q;
    acc_v   <= m_v;
    acc_s   <= m_s;
    if (rst) begin
      p_live <= 1'b0;
    end else begin
      p_live <= (state == S_SWEEP);
    end
  end

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= HB'(8);
    end else if (cfg_valid && cfg_ready) begin
      rows_in_use <= cfg_data;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      have_held <= 1'b0;
      bank      <= 1'b0;
      fresh     <= 1'b1;
      best      <= '0;
      out_valid <= 1'b0;
      phase     <= 1'b0;
      row       <= '0;
      q         <= '0;
      slot      <= SLOT_A;
    end else begin
      if (out_valid && !out_stall && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      if (p_live && p_slot == SLOT_C && last_row && m_v && sat_s > best) begin
        best <= sat_s;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            for (int i = 0; i < dpdp_pkg::MAX_ROWS; i++) begin
              newcol[i] <= incol[i];
            end
            last_q <= last_column;
            hgt    <= (rows_in_use == '0) ? HB'(1) :
                      (rows_in_use > HB'(dpdp_pkg::MAX_ROWS)) ? HB'(dpdp_pkg::MAX_ROWS) :
                      rows_in_use;
            phase  <= 1'b0;
            row    <= '0;
            state  <= have_held ? S_ROWSET : S_INIT;
          end
        end
        S_INIT: begin
          if (last_q) begin
            phase <= 1'b1;
            state <= S_ROWSET;
          end else begin
            state <= S_FIN;
          end
        end
        S_ROWSET: begin
          sv_pos <= (sum_v > 0);
          sh_pos <= (sum_h > 0);
          sv     <= DB'(sum_v);
          sh     <= DB'(sum_h);
          q      <= '0;
          slot   <= SLOT_A;
          state  <= S_SWEEP;
        end
        S_SWEEP: begin
          if (slot == SLOT_C) begin
            slot <= SLOT_A;
            q    <= q + MB'(1);
            if (q == '1) begin
              state <= S_DRAIN;
            end
          end else begin
            slot <= slot + 2'd1;
          end
        end
        S_DRAIN: begin
          bank  <= ~bank;
          fresh <= 1'b0;
          if (last_row) begin
            if (!phase && last_q) begin
              phase <= 1'b1;
              row   <= '0;
              state <= S_ROWSET;
            end else begin
              state <= S_FIN;
            end
          end else begin
            row   <= row + RB'(1);
            state <= S_ROWSET;
          end
        end
        S_FIN: begin
          if (!out_valid || !out_stall) begin
            best_total   <= best[dpdp_pkg::OUT_BITS-1:0];
            answer_final <= last_q;
            out_valid    <= 1'b1;
            for (int i = 0; i < dpdp_pkg::MAX_ROWS; i++) begin
              held[i] <= newcol[i];
            end
            if (last_q) begin
              have_held <= 1'b0;
              best      <= '0;
              fresh     <= 1'b1;
            end else begin
              have_held <= 1'b1;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // checks
  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    !(we && state == S_IDLE))
    else $error("score write while idle");
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("block not busy after request");
  a_best_capped: assert property (@(posedge clk) disable iff (rst)
    best <= dpdp_pkg::SCORE_CAP)
    else $error("best exceeds score ceiling");
  a_final_resets: assert property (@(posedge clk) disable iff (rst)
    ($rose(out_valid) && answer_final) |-> (!have_held && best == '0))
    else $error("grid state not returned to reset after final answer");
endmodule
`default_nettype wire

>>> tb/domino_profile_dp_tb.sv
// domino_profile_dp_tb: self-checking bench for the domino profile block, with a column
// predictor, random input idles, random output stalls and height changes; depends on dpdp_pkg
`timescale 1ns / 1ps
`default_nettype none
module domino_profile_dp_tb;
  localparam int MAX_ROWS   = dpdp_pkg::MAX_ROWS;
  localparam int CELL_BITS  = dpdp_pkg::CELL_BITS;
  localparam int SCORE_BITS = dpdp_pkg::SCORE_BITS;
  localparam int OUT_BITS   = dpdp_pkg::OUT_BITS;
  localparam int HGT_BITS   = dpdp_pkg::HGT_BITS;
  localparam int NMASKS     = dpdp_pkg::NMASKS;

  localparam longint unsigned TOTAL_CAP = (64'd1 << (SCORE_BITS - 1)) - 64'd1;

  typedef logic signed [CELL_BITS-1:0] cell_t;
  typedef cell_t column_t [MAX_ROWS];

  // expected grid totals from a broken-profile model of the block
  class domino_score_board;
    int unsigned height_reg;
    longint unsigned score [NMASKS];
    bit reach [NMASKS];
    longint unsigned nscore [NMASKS];
    bit nreach [NMASKS];
    longint held [MAX_ROWS];
    bit have_held;
    longint unsigned best;
    int hgt;
    bit horiz;
    longint cur [MAX_ROWS];
    longint nxt [MAX_ROWS];
    longint unsigned base_total;
    longint unsigned want_total [$];
    bit want_final [$];
    int mismatches;
    int results;
    int grids;

    function new();
      height_reg = 8;
      mismatches = 0;
      results = 0;
      grids = 0;
      clear_grid();
    endfunction

    function void clear_grid();
      foreach (reach[m]) begin
        reach[m] = 0;
        nreach[m] = 0;
        score[m] = 0;
      end
      reach[0] = 1;
      have_held = 0;
      best = 0;
    endfunction

    // place dominoes row by row; horizontals mark the next column
    function void place(int row, int occ, int nmask, longint add);
      longint s;
      longint unsigned t;
      if (row >= hgt) begin
        t = base_total + longint'(add);
        if (t > TOTAL_CAP) t = TOTAL_CAP;
        if (!nreach[nmask] || nscore[nmask] < t) begin
          nscore[nmask] = t;
          nreach[nmask] = 1;
        end
        if (t > best) best = t;
        return;
      end
      if (occ[row] == 0) begin
        if (row + 1 < hgt && occ[row+1] == 0) begin
          s = cur[row] + cur[row+1];
          if (s > 0) place(row + 2, occ, nmask, add + s);
        end
        if (horiz) begin
          s = cur[row] + nxt[row];
          if (s > 0) place(row + 1, occ, nmask | (1 << row), add + s);
        end
      end
      place(row + 1, occ, nmask, add);
    endfunction

    function void sweep(bit with_horiz);
      horiz = with_horiz;
      foreach (nreach[m]) nreach[m] = 0;
      for (int m = 0; m < (1 << hgt); m++) begin
        if (reach[m]) begin
          base_total = score[m];
          place(0, m, 0, 0);
        end
      end
      foreach (score[m]) begin
        score[m] = nscore[m];
        reach[m] = nreach[m];
      end
    endfunction

    function void note_request(column_t col, bit last);
      hgt = height_reg;
      if (hgt < 1) hgt = 1;
      if (hgt > MAX_ROWS) hgt = MAX_ROWS;
      if (have_held) begin
        foreach (cur[r]) begin
          cur[r] = held[r];
          nxt[r] = longint'(col[r]);
        end
        sweep(1);
      end
      foreach (held[r]) held[r] = longint'(col[r]);
      have_held = 1;
      if (last) begin
        foreach (cur[r]) begin
          cur[r] = longint'(col[r]);
          nxt[r] = 0;
        end
        sweep(0);
      end
      want_total.push_back(best & ((64'd1 << OUT_BITS) - 1));
      want_final.push_back(last);
      if (last) begin
        clear_grid();
        grids++;
      end
    endfunction

    function void check_result(logic [OUT_BITS-1:0] got_total, logic got_final);
      longint unsigned et;
      bit ef;
      results++;
      if (want_total.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: best_total %0d answer_final %0d", got_total, got_final);
        return;
      end
      et = want_total.pop_front();
      ef = want_final.pop_front();
      if (got_total !== et[OUT_BITS-1:0] || got_final !== ef) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch on result %0d: best_total exp %0d got %0d, answer_final exp %0d got %0d",
                   results, et, got_total, ef, got_final);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  cell_t cells [MAX_ROWS];
  logic last_column;
  logic out_valid;
  logic out_stall;
  logic [OUT_BITS-1:0] best_total;
  logic answer_final;
  logic cfg_valid;
  logic cfg_ready;
  logic [HGT_BITS-1:0] cfg_data;

  domino_score_board sb;
  int send_idle_pct;
  int recv_stall_pct;
  int columns_sent;

  domino_profile_dp u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .cell_0(cells[0]), .cell_1(cells[1]), .cell_2(cells[2]), .cell_3(cells[3]),
    .cell_4(cells[4]), .cell_5(cells[5]), .cell_6(cells[6]), .cell_7(cells[7]),
    .last_column(last_column),
    .out_valid(out_valid), .out_stall(out_stall),
    .best_total(best_total), .answer_final(answer_final),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // clock
  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // receiver stalls
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(best_total, answer_final);
  end

  // hard time limit
  initial begin
    #(64'd40_000_000 * 20);
    $display("tb: failure");
    $finish;
  end

  // present one column and hold it until accepted
  task automatic send_column(column_t col, bit last);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1;
    foreach (cells[r]) cells[r] <= col[r];
    last_column <= last;
    do @(posedge clk); while (in_stall);
    sb.note_request(col, last);
    columns_sent++;
  endtask

  // drain every pending result, then write the height register
  task automatic write_height(logic [HGT_BITS-1:0] h);
    in_valid <= 0;
    while (sb.want_total.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_valid <= 1;
    cfg_data <= h;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    sb.height_reg = h;
  endtask

  function automatic column_t rand_column(int style);
    column_t c;
    foreach (c[r]) begin
      case (style)
        0: c[r] = cell_t'($urandom());
        1: c[r] = cell_t'($urandom_range(200) - 60);
        2: c[r] = ($urandom_range(1)) ? 16'sh7fff : 16'sh8000;
        default: c[r] = cell_t'($urandom_range(4000) - 2000);
      endcase
    end
    return c;
  endfunction

  function automatic column_t fill_column(cell_t v);
    column_t c;
    foreach (c[r]) c[r] = v;
    return c;
  endfunction

  task automatic send_grid(int ncols, int style);
    for (int i = 0; i < ncols; i++) send_column(rand_column(style), i == ncols - 1);
  endtask

  initial begin
    column_t col;
    int h;
    sb = new();
    rst = 1;
    in_valid = 0;
    foreach (cells[r]) cells[r] = '0;
    last_column = 0;
    out_stall = 0;
    cfg_valid = 0;
    cfg_data = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    columns_sent = 0;
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: extremes at full height, one-column grids, odd heights
    send_column(fill_column(16'sh7fff), 0);
    send_column(fill_column(16'sh7fff), 0);
    send_column(fill_column(16'sh8000), 1);
    send_column(fill_column(16'sh7fff), 1);
    send_column(rand_column(2), 0);
    send_column(rand_column(1), 1);
    write_height(HGT_BITS'(0));
    send_column(fill_column(16'sh0005), 0);
    send_column(fill_column(16'sh0007), 1);
    write_height(HGT_BITS'(15));
    send_column(rand_column(1), 0);
    send_column(rand_column(1), 1);
    write_height(HGT_BITS'(1));
    send_column(fill_column(16'sh0001), 0);
    send_column(fill_column(16'shffff), 0);
    send_column(fill_column(16'sh0002), 1);
    // height changed mid-grid, both ways
    write_height(HGT_BITS'(3));
    send_column(rand_column(1), 0);
    send_column(rand_column(1), 0);
    write_height(HGT_BITS'(2));
    send_column(rand_column(1), 0);
    write_height(HGT_BITS'(4));
    send_column(rand_column(1), 1);
    write_height(HGT_BITS'(9));
    send_column(rand_column(3), 0);
    send_column(rand_column(3), 1);

    // random grids in three idling phases
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 20 : (phase == 1) ? 74 : 0;
      recv_stall_pct = (phase == 0) ? 74 : (phase == 1) ? 20 : 0;
      while (columns_sent < 25 + (phase + 1) * 88) begin
        if ($urandom_range(3) == 0) begin
          h = $urandom_range(9);
          if (h == 9) h = 8 + $urandom_range(7);
          else if (h > 3) h = $urandom_range(1, 3);
          write_height(h[HGT_BITS-1:0]);
        end
        if ($urandom_range(9) == 0) begin
          // broken grid: height switched between columns
          send_column(rand_column(1), 0);
          write_height(HGT_BITS'($urandom_range(1, 3)));
          send_column(rand_column(0), 1);
        end else begin
          send_grid($urandom_range(1, 5), $urandom_range(3));
        end
      end
    end

    // wind down
    in_valid <= 0;
    while (sb.want_total.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("covered %0d columns in %0d grids, %0d results checked, %0d mismatches",
             columns_sent, sb.grids, sb.results, sb.mismatches);
    if (sb.mismatches == 0 && sb.want_total.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
`default_nettype wire
